>>> hw/rtl/mat_pkg.sv
package mat_pkg;

   // fixed field widths
   localparam int SAMPLE_W   = 16;
   localparam int LEN_W      = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_WINDOW    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_THRESHOLD = 1'b1;

   // register reset values
   localparam logic [LEN_W-1:0]    RESET_WINDOW_LENGTH     = 7'd10;
   localparam logic [SAMPLE_W-1:0] RESET_WARNING_THRESHOLD = 16'd7168;

   // controller to datapath
   typedef struct packed {
      logic load_sample;
      logic update;
      logic div_start;
      logic div_step;
      logic load_out;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_last;
   } dp_sts_type;

endpackage

>>> hw/rtl/mat_ram.sv
module mat_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/mat_ctrl.sv
module mat_ctrl import mat_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_UPDATE = 5'b00010,
      ST_PREP   = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_sample = 1'b1;
               state_in        = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_PREP;
         end
         ST_PREP: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/mat_dp.sv
module mat_dp import mat_pkg::*; #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts,
   input  logic [SAMPLE_W-1:0]   req_tdata,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CW    = $clog2(MAX_WINDOW + 1);
   localparam int SW    = SAMPLE_W + $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(SW);

   // configuration
   logic [LEN_W-1:0]           window_len_ff;
   logic signed [SAMPLE_W-1:0] threshold_ff;
   logic [CW-1:0]              eff_len;

   // window state
   logic [AW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        fill_ff, fill_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic                 clear;
   logic [AW-1:0]        pos_eff;
   logic [CW-1:0]        pos_next;
   logic                 full;

   // sample and ram
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] old_sample;
   logic [SAMPLE_W-1:0]        rd_data;

   // divider
   logic [SW-1:0]    dq_ff;
   logic [CW-1:0]    rem_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CW:0]      rem_sh;
   logic             q_bit;
   logic [SW-1:0]    sum_mag;
   logic [SW-1:0]    q_signed;

   // result
   logic signed [SAMPLE_W-1:0] mean;
   logic [SAMPLE_W-1:0]        avg_ff;
   logic                       above_ff;
   logic [LEN_W-1:0]           used_ff;

   always_comb begin
      if (window_len_ff == '0) begin
         eff_len = CW'(1);
      end else if (int'(window_len_ff) > MAX_WINDOW) begin
         eff_len = CW'(MAX_WINDOW);
      end else begin
         eff_len = CW'(window_len_ff);
      end
   end

   assign clear = csr_we && ((csr_index == CSR_IDX_WINDOW) || (csr_index == CSR_IDX_THRESHOLD));

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= RESET_WINDOW_LENGTH;
         threshold_ff  <= RESET_WARNING_THRESHOLD;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IDX_WINDOW:    window_len_ff <= csr_wdata[LEN_W-1:0];
            CSR_IDX_THRESHOLD: threshold_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign pos_eff  = (CW'(pos_ff) >= eff_len) ? '0 : pos_ff;
   assign pos_next = CW'(pos_eff) + CW'(1);
   assign full     = (fill_ff >= eff_len);
   assign old_sample = rd_data;

   always_comb begin
      pos_in  = pos_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (clear) begin
         pos_in  = '0;
         fill_in = '0;
         sum_in  = '0;
      end else if (cmd.update) begin
         pos_in = (pos_next >= eff_len) ? '0 : AW'(pos_next);
         if (full) begin
            fill_in = eff_len;
            sum_in  = sum_ff - SW'(old_sample) + SW'(sample_ff);
         end else begin
            fill_in = fill_ff + CW'(1);
            sum_in  = sum_ff + SW'(sample_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sample_ff <= req_tdata;
      end
   end

   // read port follows the current slot, so the oldest sample is ready after accept
   mat_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WINDOW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (pos_eff),
      .wr_data (sample_ff),
      .rd_addr (pos_eff),
      .rd_data (rd_data)
   );

   // restoring divide of |sum| by fill count, one quotient bit per step
   assign sum_mag = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
   assign rem_sh  = {rem_ff, dq_ff[SW-1]};
   assign q_bit   = (rem_sh >= {1'b0, fill_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.div_start) begin
         cnt_ff <= CNT_W'(SW - 1);
      end else if (cmd.div_step && (cnt_ff != '0)) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dq_ff  <= sum_mag;
         rem_ff <= '0;
         neg_ff <= sum_ff[SW-1];
      end else if (cmd.div_step) begin
         dq_ff  <= {dq_ff[SW-2:0], q_bit};
         rem_ff <= q_bit ? CW'(rem_sh - {1'b0, fill_ff}) : CW'(rem_sh);
      end
   end

   assign sts.div_last = (cnt_ff == '0);

   assign q_signed = neg_ff ? (-dq_ff) : dq_ff;
   assign mean     = q_signed[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         avg_ff   <= mean;
         above_ff <= (mean > threshold_ff);
         used_ff  <= LEN_W'(fill_ff);
      end
   end

   assign rsp_tdata = {used_ff, above_ff, avg_ff};

endmodule

>>> hw/rtl/moving_average_threshold.sv
// moving average with threshold flag, one sample beat in, one result beat out
// one sample is in work at a time: the next beat is taken only after the last result has been
// loaded into the output register, which may wait while rsp_tready holds back the previous result
// the pace is set by the bit-serial restoring divider, SUM_W = 16 + clog2(MAX_WINDOW) quotient bits
// reset: synchronous active-high; window empty, window_length 10, threshold 28.0 degC
// the window store has no reset; it is only read at slots written since the last clear
module moving_average_threshold import mat_pkg::*; #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // sample beats
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // [15:0] sample
   // result beats
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [15:0] average, [16] above_threshold,
                                              // [23:17] samples_used
   // register writes, any write clears the window
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // command and status between controller and datapath
   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer: accept, window update, divider load, divide, result hand-off
   mat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // window ram, running sum, fill count, divider and output register
   mat_dp #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

>>> hw/rtl/mat_checker.sv
module mat_checker import mat_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic req_beat;
   assign req_beat = req_tvalid && req_tready;

   // a stalled result beat holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // one item at a time: no second sample right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_tready)
      else $error("sample accepted while busy");

   // the window update and the divide lie between accept and result, so a result cannot appear right after an accept
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !$rose(rsp_tvalid))
      else $error("result appeared too soon after sample");

   // reset drops any pending result
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind moving_average_threshold mat_checker u_mat_checker (.*);

>>> dv/moving_average_checker.sv
module moving_average_checker import mat_pkg::*; #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // [15:0] sample
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [15:0] average, [16] above_threshold,
                                              // [23:17] samples_used
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    pending
);

   localparam int HIST_AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] average;
      logic                       above_threshold;
      logic [LEN_W-1:0]           samples_used;
   } mean_result_type;

   logic [LEN_W-1:0]           window_length;
   logic signed [SAMPLE_W-1:0] threshold;
   logic signed [SAMPLE_W-1:0] history [MAX_WINDOW];
   int                         slot;
   int                         held;
   int                         total;
   mean_result_type            expected_means [$];

   function automatic mean_result_type next_mean(input logic signed [SAMPLE_W-1:0] sample);
      int              span;
      int              quotient;
      mean_result_type result;
      span = (window_length == '0) ? 1 : int'(window_length);
      if (span > MAX_WINDOW) span = MAX_WINDOW;
      if (slot >= span) slot = 0;
      // full window: the oldest sample leaves the sum
      if (held >= span) begin
         total -= history[HIST_AW'(slot)];
         held = span;
      end else begin
         held++;
      end
      history[HIST_AW'(slot)] = sample;
      total += sample;
      slot = (slot + 1 >= span) ? 0 : slot + 1;
      quotient = total / held;
      result.average         = quotient[SAMPLE_W-1:0];
      result.above_threshold = (quotient > threshold);
      result.samples_used    = held[LEN_W-1:0];
      return result;
   endfunction

   function automatic void compare_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $error("%s expected %0d actual %0d", field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      mean_result_type want;
      if (reset) begin
         window_length = RESET_WINDOW_LENGTH;
         threshold     = RESET_WARNING_THRESHOLD;
         slot          = 0;
         held          = 0;
         total         = 0;
         mismatches    = 0;
         expected_means.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_means.size() == 0) begin
               mismatches++;
               $error("result beat with no sample outstanding, tdata %h", rsp_tdata);
            end else begin
               want = expected_means.pop_front();
               compare_field("average", want.average, $signed(rsp_tdata[15:0]));
               compare_field("above_threshold", want.above_threshold, rsp_tdata[16]);
               compare_field("samples_used", want.samples_used, rsp_tdata[23:17]);
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_IDX_WINDOW) window_length = csr_wdata[LEN_W-1:0];
            if (csr_index == CSR_IDX_THRESHOLD) threshold = csr_wdata;
            // each index the port can carry names a register, so every write empties the window
            slot  = 0;
            held  = 0;
            total = 0;
         end
         if (req_tvalid && req_tready)
            expected_means = {expected_means, next_mean(req_tdata)};
      end
      pending = expected_means.size();
   end

endmodule

>>> dv/tb.sv
module tb;
   import mat_pkg::*;

   localparam int WINDOW_DEPTH     = 64;
   localparam int ITEM_TARGET      = 1400;   // sample beats before the stimulus stops
   localparam int LONG_HOLD_CYCLES = 600;    // result side held off long enough to back up input
   localparam int DRAIN_CYCLES     = 60;     // extra wait to catch stray result beats
   localparam int TIMEOUT_CYCLES   = 1_500_000;

   // opening samples at the default setup: threshold edges, full scale, sign edges, wrap at 11
   localparam logic [SAMPLE_W-1:0] OPENING_SAMPLES [12] = '{
      16'd7169, 16'd7168, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
      16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h7FFF
   };

   localparam logic [SAMPLE_W-1:0] CORNER_SAMPLES [7] = '{
      16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001, 16'h7FFE
   };

   // how the samples of one phase are drawn
   typedef enum {
      MIX_WIDE,
      MIX_RAIL_HIGH,
      MIX_RAIL_LOW,
      MIX_NEAR_THRESHOLD,
      MIX_FULL_SCALE_HIGH,
      MIX_FULL_SCALE_LOW
   } sample_mix_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata;   // [15:0] sample
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [15:0] average, [16] above_threshold, [23:17] samples_used
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatches;
   int pending;

   // idling controls for the sender (steady_req) and the receiver (steady_rsp, hold_results)
   logic steady_req   = 1'b0;
   logic steady_rsp   = 1'b0;
   logic hold_results = 1'b0;

   // threshold as last written, only to aim samples near it
   logic signed [SAMPLE_W-1:0] live_threshold = RESET_WARNING_THRESHOLD;
   int samples_sent = 0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   moving_average_threshold #(
      .MAX_WINDOW(WINDOW_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   moving_average_checker #(
      .MAX_WINDOW(WINDOW_DEPTH)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // idle length in cycles: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(24, 4);
      return $urandom_range(150, 40);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample(input sample_mix_type mix);
      int roll;
      roll = $urandom_range(99);
      case (mix)
         MIX_RAIL_HIGH:       return (roll < 90) ? 16'h7FFF : 16'h7FFF - 16'($urandom_range(255));
         MIX_RAIL_LOW:        return (roll < 90) ? 16'h8000 : 16'h8000 + 16'($urandom_range(255));
         MIX_NEAR_THRESHOLD:  return live_threshold + 16'($urandom_range(64)) - 16'd32;
         MIX_FULL_SCALE_HIGH: return 16'h7FFF;
         MIX_FULL_SCALE_LOW:  return 16'h8000;
         default: begin
            if (roll < 15) return CORNER_SAMPLES[3'($urandom_range(6))];
            if (roll < 40) return live_threshold + 16'($urandom_range(128)) - 16'd64;
            return 16'($urandom);
         end
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] pick_window();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8)  return '0;           // zero acts as a window of one
      if (roll < 16) return 7'd1;
      if (roll < 24) return 7'(WINDOW_DEPTH);
      if (roll < 30) return 7'd127;       // saturates to the full store
      if (roll < 36) return 7'(WINDOW_DEPTH + 1);
      if (roll < 70) return 7'($urandom_range(16, 2));
      return 7'($urandom_range(127));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_threshold();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return 16'h8000;
      if (roll < 20) return 16'h7FFF;
      if (roll < 50) return 16'($urandom);
      return 16'($urandom_range(4096) - 2048);   // near the mean of wide samples
   endfunction

   // offer one sample beat, hold it until taken, then maybe idle;
   // with no idle the valid stays high for the next call
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
      int gap;
      req_tvalid = 1'b1;
      req_tdata  = sample;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      samples_sent++;
      gap = steady_req ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_results_drained();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // registers change only with the block idle
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      wait_results_drained();
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (index == CSR_IDX_THRESHOLD) live_threshold = value;
   endtask

   // result side: random ready pattern, or one long hold-off on request
   initial begin : receiver
      int   gap;
      logic hold_taken;
      hold_taken = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_results && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else begin
            gap = steady_rsp ? 0 : pick_gap();
            rsp_tready = (gap == 0);
            if (gap > 1) repeat (gap - 1) @(negedge clock);
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * 4);
      $display("moving_average_threshold verification failed");
      $finish;
   end

   initial begin : stimulus
      int             phase;
      int             burst;
      int             roll;
      sample_mix_type mix;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_IDX_WINDOW;
      csr_wdata  = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // default window of ten, threshold 28.0 degC
      foreach (OPENING_SAMPLES[i]) send_sample(OPENING_SAMPLES[i]);

      // window field zero with the upper data bits set
      write_register(CSR_IDX_WINDOW, 16'hFF80);
      send_sample(16'hFFFD);
      send_sample(16'h0005);
      send_sample(16'h8000);

      // lowest threshold: a mean equal to it does not raise the flag
      write_register(CSR_IDX_THRESHOLD, 16'h8000);
      send_sample(16'h8000);
      send_sample(16'h8001);

      // oversized window saturates, highest threshold can never be passed
      write_register(CSR_IDX_WINDOW, 16'h007F);
      write_register(CSR_IDX_THRESHOLD, 16'h7FFF);
      send_sample(16'h7FFF);
      send_sample(16'h7FFF);
      send_sample(16'h8000);

      // result side held off while beats keep coming, the block backs up and stalls input
      write_register(CSR_IDX_THRESHOLD, 16'h0000);
      hold_results = 1'b1;
      steady_req   = 1'b1;
      repeat (24) send_sample(pick_sample(MIX_WIDE));
      steady_req = 1'b0;
      // sender pauses until every result is back
      wait_results_drained();

      // random phases, each opened by register writes (or none, to keep the window running)
      phase = 0;
      while (samples_sent < ITEM_TARGET) begin
         if (phase == 0) begin
            // full store of the largest sample, sum at its top
            write_register(CSR_IDX_WINDOW, {9'($urandom), 7'd127});
            mix   = MIX_FULL_SCALE_HIGH;
            burst = 80;
         end else if (phase == 1) begin
            // full store of the smallest sample, sum at its bottom
            write_register(CSR_IDX_WINDOW, 16'(WINDOW_DEPTH));
            mix   = MIX_FULL_SCALE_LOW;
            burst = 80;
         end else begin
            roll = $urandom_range(99);
            if (roll < 45) begin
               write_register(CSR_IDX_WINDOW, {9'($urandom), pick_window()});
            end else if (roll < 75) begin
               write_register(CSR_IDX_THRESHOLD, pick_threshold());
            end else if (roll < 90) begin
               write_register(CSR_IDX_WINDOW, {9'($urandom), pick_window()});
               write_register(CSR_IDX_THRESHOLD, pick_threshold());
            end
            mix   = sample_mix_type'($urandom_range(3));
            burst = ($urandom_range(9) == 0) ? $urandom_range(200, 70) : $urandom_range(40, 3);
         end
         // some phases run with no idling on one side or both
         steady_req = ($urandom_range(4) == 0);
         steady_rsp = ($urandom_range(4) == 0);
         repeat (burst) send_sample(pick_sample(mix));
         phase++;
      end
      steady_req = 1'b0;
      steady_rsp = 1'b0;

      wait_results_drained();
      // catch any stray result beats
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("moving_average_threshold verification clean");
      end else begin
         $display("moving_average_threshold verification failed");
      end
      $finish;
   end

endmodule
